>>> rtl/core/pcvdf_pkg.sv
// ----------------------------------------------------------------------------
// pcvdf_pkg
// Shared types, constants and helper functions of the voxel dedup filter.
// ----------------------------------------------------------------------------
package pcvdf_pkg;

    localparam int TABLE_ENTRIES    = 4096;
    localparam int ADDR_W           = $clog2(TABLE_ENTRIES);
    localparam int CNT_W            = ADDR_W + 1;
    localparam int VOXEL_INDEX_BITS = 21;
    localparam int KEY_W            = 3 * VOXEL_INDEX_BITS;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 64;

    // Sampling is on below 1000.0 in Q12.12
    localparam logic [23:0] SAMPLING_LIMIT = 24'd4096000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOXEL  = 4'd7;

    // Input op codes
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               invalid;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
        logic               table_overflow;
    } out_item_t;

    typedef struct packed {
        logic [59:0]        rot_row_x;
        logic [59:0]        rot_row_y;
        logic [59:0]        rot_row_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic [63:0]        range_limit_sq;
        logic [23:0]        voxel_inverse;
    } cfg_t;

    typedef struct packed {
        logic [63:0]        dist_sq;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic [KEY_W-1:0]   key;
    } arith_res_t;

    typedef struct packed {
        logic hit;
        logic overflow;
    } tbl_res_t;

    // Saturate a 37-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [36:0] hi;
        logic signed [36:0] lo;
        begin
            hi = 37'sd2147483647;
            lo = -37'sd2147483648;
            if (v > hi)
                sat32 = 32'sh7FFFFFFF;
            else if (v < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

    // Saturate a floored voxel index to VOXEL_INDEX_BITS signed bits
    function automatic logic [VOXEL_INDEX_BITS-1:0] vox_field(input logic signed [28:0] v);
        logic signed [28:0] hi;
        logic signed [28:0] lo;
        begin
            hi = 29'sd1 <<< (VOXEL_INDEX_BITS - 1);
            hi = hi - 29'sd1;
            lo = -hi - 29'sd1;
            if (v > hi)
                vox_field = hi[VOXEL_INDEX_BITS-1:0];
            else if (v < lo)
                vox_field = lo[VOXEL_INDEX_BITS-1:0];
            else
                vox_field = v[VOXEL_INDEX_BITS-1:0];
        end
    endfunction

endpackage

>>> rtl/core/pcvdf_ram.sv
// ----------------------------------------------------------------------------
// pcvdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcvdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/pcvdf_arith.sv
// ----------------------------------------------------------------------------
// pcvdf_arith
// Shared-multiplier sequencer: range sum, rotation plus translation and voxel
// key, one product per cycle, accumulated in the next cycle.
// ----------------------------------------------------------------------------
module pcvdf_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pcvdf_pkg::in_item_t pt,
    input  pcvdf_pkg::cfg_t     cfg,
    output logic                done,
    output pcvdf_pkg::arith_res_t res
);
    import pcvdf_pkg::*;

    logic               run_reg, run_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               stv_reg;
    logic [3:0]         step_reg;
    logic signed [65:0] prod_reg;
    logic signed [32:0] op_a, op_b;
    logic signed [53:0] acc_reg;
    logic signed [53:0] acc_sum;
    logic signed [36:0] axis_sum;
    logic signed [28:0] vox_fl;
    logic               done_reg;

    // Select the multiplier operands for this step
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cnt_reg)
            4'd0:  begin op_a = 33'(pt.pos_x); op_b = 33'(pt.pos_x); end
            4'd1:  begin op_a = 33'(pt.pos_y); op_b = 33'(pt.pos_y); end
            4'd2:  begin op_a = 33'(pt.pos_z); op_b = 33'(pt.pos_z); end
            4'd3:  begin op_a = 33'($signed(cfg.rot_row_x[19:0]));  op_b = 33'(pt.pos_x); end
            4'd4:  begin op_a = 33'($signed(cfg.rot_row_x[39:20])); op_b = 33'(pt.pos_y); end
            4'd5:  begin op_a = 33'($signed(cfg.rot_row_x[59:40])); op_b = 33'(pt.pos_z); end
            4'd6:  begin op_a = 33'($signed(cfg.rot_row_y[19:0]));  op_b = 33'(pt.pos_x); end
            4'd7:  begin op_a = 33'($signed(cfg.rot_row_y[39:20])); op_b = 33'(pt.pos_y); end
            4'd8:  begin op_a = 33'($signed(cfg.rot_row_y[59:40])); op_b = 33'(pt.pos_z); end
            4'd9:  begin op_a = 33'($signed(cfg.rot_row_z[19:0]));  op_b = 33'(pt.pos_x); end
            4'd10: begin op_a = 33'($signed(cfg.rot_row_z[39:20])); op_b = 33'(pt.pos_y); end
            4'd11: begin op_a = 33'($signed(cfg.rot_row_z[59:40])); op_b = 33'(pt.pos_z); end
            4'd13: begin op_a = 33'(res.ox); op_b = $signed({9'd0, cfg.voxel_inverse}); end
            4'd14: begin op_a = 33'(res.oy); op_b = $signed({9'd0, cfg.voxel_inverse}); end
            4'd15: begin op_a = 33'(res.oz); op_b = $signed({9'd0, cfg.voxel_inverse}); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // Advance the step counter
    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            stv_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            stv_reg  <= run_reg;
            done_reg <= stv_reg && (step_reg == 4'd15);
        end
    end

    assign acc_sum  = acc_reg + prod_reg[53:0];
    assign axis_sum = 37'(acc_sum >>> 18);
    assign vox_fl   = 29'(prod_reg[56:0] >>> 28);

    // Multiply, then accumulate the previous product
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        step_reg <= cnt_reg;
        if (stv_reg)
        begin
            case (step_reg)
                4'd0:  res.dist_sq <= prod_reg[63:0];
                4'd1,
                4'd2:  res.dist_sq <= res.dist_sq + prod_reg[63:0];
                4'd3,
                4'd6,
                4'd9:  acc_reg <= prod_reg[53:0];
                4'd4,
                4'd7,
                4'd10: acc_reg <= acc_sum;
                4'd5:  res.ox <= sat32(axis_sum + 37'(cfg.shift_x));
                4'd8:  res.oy <= sat32(axis_sum + 37'(cfg.shift_y));
                4'd11: res.oz <= sat32(axis_sum + 37'(cfg.shift_z));
                4'd13: res.key[VOXEL_INDEX_BITS-1:0] <= vox_field(vox_fl);
                4'd14: res.key[2*VOXEL_INDEX_BITS-1:VOXEL_INDEX_BITS] <= vox_field(vox_fl);
                4'd15: res.key[KEY_W-1:2*VOXEL_INDEX_BITS] <= vox_field(vox_fl);
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign done = done_reg;

endmodule

>>> rtl/core/pcvdf_table.sv
// ----------------------------------------------------------------------------
// pcvdf_table
// Visited-voxel table: key memory filled in order, scanned one entry a cycle,
// new key appended at the fill count while there is room.
// ----------------------------------------------------------------------------
module pcvdf_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         start,
    input  logic [pcvdf_pkg::KEY_W-1:0]  key,
    output logic                         done,
    output pcvdf_pkg::tbl_res_t          res
);
    import pcvdf_pkg::*;

    logic             busy_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             pend_reg;
    logic             issue;
    logic             hit;
    logic             finish;
    logic             room;
    logic             done_reg;
    tbl_res_t         res_reg;
    logic [KEY_W-1:0] rdata;

    assign issue  = busy_reg && (idx_reg < used_reg);
    assign hit    = busy_reg && pend_reg && (rdata == key);
    assign finish = busy_reg && !hit && !pend_reg && !issue;
    assign room   = (used_reg < CNT_W'(TABLE_ENTRIES));

    pcvdf_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_keys (
        .clk   (clk),
        .we    (finish && room),
        .waddr (used_reg[ADDR_W-1:0]),
        .wdata (key),
        .re    (issue),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    // Scan, then report a hit, or append the key or report overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            used_reg <= '0;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (clear)
                used_reg <= '0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                pend_reg <= issue;
                if (issue)
                    idx_reg <= idx_reg + CNT_W'(1);
                if (hit)
                begin
                    busy_reg     <= 1'b0;
                    done_reg     <= 1'b1;
                    res_reg.hit  <= 1'b1;
                    res_reg.overflow <= 1'b0;
                end
                else if (finish)
                begin
                    busy_reg     <= 1'b0;
                    done_reg     <= 1'b1;
                    res_reg.hit  <= 1'b0;
                    res_reg.overflow <= !room;
                    if (room)
                        used_reg <= used_reg + CNT_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> rtl/core/point_cloud_voxel_dedup_filter_top.sv
// ----------------------------------------------------------------------------
// point_cloud_voxel_dedup_filter_top
// Range gate, rigid transform and voxel-grid duplicate suppression of points.
// ----------------------------------------------------------------------------
// One item at a time. A point is taken in the idle state and then runs the
// shared multiplier sequence (three squares, nine rotation products, three
// voxel products), then, with sampling on, the voxel table, where the voxels
// recorded so far in the frame are scanned: the key memory is read one entry
// per cycle through its single read port, and a hit ends the scan early. A
// color test and the load of the output register follow; the load waits while
// the output is stalled. A frame-start item or an invalid point is absorbed in
// the idle state. A finished point waits in the output register while the
// next item is taken.
module point_cloud_voxel_dedup_filter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  pcvdf_pkg::in_item_t                   in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output pcvdf_pkg::out_item_t                  out_item,
    input  logic                                  cfg_we,
    input  logic [pcvdf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcvdf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pcvdf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ARITH = 3'd1;
    localparam logic [2:0] ST_TABLE = 3'd2;
    localparam logic [2:0] ST_COLOR = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    cfg_t        cfg_reg;
    in_item_t    pt_reg;
    logic        ovf_reg, ovf_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg;
    logic        accept;
    logic        arith_start, arith_done;
    logic        arith_start_q;
    arith_res_t  ares;
    logic        tbl_start, tbl_done, tbl_clear;
    tbl_res_t    tres;
    logic        sampling;
    logic        load_out;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign sampling = (cfg_reg.voxel_inverse != 24'd0) &&
                      (cfg_reg.voxel_inverse < SAMPLING_LIMIT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_row_x      <= 60'd262144;
            cfg_reg.rot_row_y      <= 60'd274877906944;
            cfg_reg.rot_row_z      <= 60'd288230376151711744;
            cfg_reg.shift_x        <= '0;
            cfg_reg.shift_y        <= '0;
            cfg_reg.shift_z        <= '0;
            cfg_reg.range_limit_sq <= 64'd4294967296;
            cfg_reg.voxel_inverse  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROT_X:   cfg_reg.rot_row_x      <= cfg_data[59:0];
                REG_ROT_Y:   cfg_reg.rot_row_y      <= cfg_data[59:0];
                REG_ROT_Z:   cfg_reg.rot_row_z      <= cfg_data[59:0];
                REG_SHIFT_X: cfg_reg.shift_x        <= cfg_data[31:0];
                REG_SHIFT_Y: cfg_reg.shift_y        <= cfg_data[31:0];
                REG_SHIFT_Z: cfg_reg.shift_z        <= cfg_data[31:0];
                REG_RANGE:   cfg_reg.range_limit_sq <= cfg_data;
                REG_VOXEL:   cfg_reg.voxel_inverse  <= cfg_data[23:0];
                default:     cfg_reg.voxel_inverse  <= cfg_reg.voxel_inverse;
            endcase
        end
    end

    pcvdf_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (arith_start),
        .pt    (pt_reg),
        .cfg   (cfg_reg),
        .done  (arith_done),
        .res   (ares)
    );

    pcvdf_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (tbl_clear),
        .start (tbl_start),
        .key   (ares.key),
        .done  (tbl_done),
        .res   (tres)
    );

    // Sequence one item
    always_comb
    begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        arith_start    = 1'b0;
        tbl_start      = 1'b0;
        tbl_clear      = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.op == OP_FRAME)
                        tbl_clear = 1'b1;
                    else if (!in_item.invalid)
                        state_next = ST_ARITH;
                end
            end
            ST_ARITH:
            begin
                if (!arith_start_q)
                    arith_start = 1'b1;
                if (arith_done)
                begin
                    ovf_next = 1'b0;
                    if (ares.dist_sq > cfg_reg.range_limit_sq)
                        state_next = ST_IDLE;
                    else if (sampling)
                    begin
                        tbl_start  = 1'b1;
                        state_next = ST_TABLE;
                    end
                    else
                        state_next = ST_COLOR;
                end
            end
            ST_TABLE:
            begin
                if (tbl_done)
                begin
                    ovf_next   = tres.overflow;
                    state_next = tres.hit ? ST_IDLE : ST_COLOR;
                end
            end
            ST_COLOR:
            begin
                if (pt_reg.red_in == 8'd0 && pt_reg.green_in == 8'd0 &&
                    pt_reg.blue_in == 8'd0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Start the sequencer once per point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            arith_start_q <= 1'b0;
        else
            arith_start_q <= (state_reg == ST_ARITH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the point and the finished item
    always_ff @(posedge clk)
    begin
        if (accept)
            pt_reg <= in_item;
        if (load_out)
        begin
            out_reg.out_x          <= ares.ox;
            out_reg.out_y          <= ares.oy;
            out_reg.out_z          <= ares.oz;
            out_reg.red_out        <= pt_reg.red_in;
            out_reg.green_out      <= pt_reg.green_in;
            out_reg.blue_out       <= pt_reg.blue_in;
            out_reg.table_overflow <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule
